FILE: sv/gbi_pkg.sv
// Shared types and constants for the grid bucket insert and visit block.
// Used by every module of the block but gbi_div; depends on nothing.
package gbi_pkg;

    localparam logic [1:0] M_INSERT = 2'd0;
    localparam logic [1:0] M_GET    = 2'd1;
    localparam logic [1:0] M_READ   = 2'd2;
    localparam logic [1:0] M_CLEAR  = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OUTSIDE = 3'd1;
    localparam logic [2:0] ST_EXHAUST = 3'd2;
    localparam logic [2:0] ST_VISITED = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;

    localparam logic [1:0] R_LAND_WIDTH  = 2'd0;
    localparam logic [1:0] R_LAND_HEIGHT = 2'd1;
    localparam logic [1:0] R_CELL_STEP   = 2'd2;
    localparam logic [1:0] R_GRID_SHIFT  = 2'd3;

    localparam logic [2:0] K_INSERT = 3'd0;
    localparam logic [2:0] K_GET    = 3'd1;
    localparam logic [2:0] K_READ   = 3'd2;
    localparam logic [2:0] K_CLEAR  = 3'd3;
    localparam logic [2:0] K_FIXED  = 3'd4;

    typedef struct packed {
        logic [12:0] land_width;
        logic [12:0] land_height;
        logic [15:0] cell_step;
        logic [2:0]  grid_shift;
    } cfg_t;

    // Work handed from the front end to the back end.
    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  status;
        logic [12:0] xt1;
        logic [12:0] xt2;
        logic [12:0] yt1;
        logic [12:0] yt2;
        logic [13:0] row;
        logic [27:0] base;   // first row base for insert, tile index for get
        logic [15:0] obj;
        logic [15:0] node;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        head_valid;
        logic [9:0]  head_node;
        logic [15:0] node_object;
        logic        next_valid;
        logic [9:0]  next_node;
        logic [13:0] cells_added;
        logic [13:0] cells_dropped;
    } res_t;

    typedef struct packed {
        logic init_done;
        logic pop;
    } bstat_t;

    function automatic res_t status_res(input logic [2:0] st);
        res_t r;
        r = '0;
        r.status = st;
        return r;
    endfunction

endpackage

FILE: sv/gbi_div.sv
// Bit-serial signed divider by an unsigned 16-bit step, truncating toward zero.
// Standalone; one quotient bit per cycle.
module gbi_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [24:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [25:0] quotient
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        neg_reg;
    logic [15:0] d_reg;
    logic [15:0] rem_reg;
    logic [24:0] quo_reg;
    logic [16:0] shifted;
    logic        ge;

    assign shifted = {rem_reg, quo_reg[24]};
    assign ge      = shifted >= {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd24)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[24];
            d_reg   <= divisor;
            rem_reg <= 16'd0;
            quo_reg <= dividend[24] ? (25'd0 - dividend) : dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 16'(shifted - {1'b0, d_reg}) : shifted[15:0];
            quo_reg <= {quo_reg[23:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (26'd0 - {1'b0, quo_reg}) : {1'b0, quo_reg};
endmodule

FILE: sv/gbi_front.sv
// Front end: accepts items, divides box corners, forms clamped tile ranges, checks gets and reads.
// Uses gbi_pkg and four gbi_div units; emits commands toward the queue.
module gbi_front
#(
    parameter int TILES      = 8192,
    parameter int POOL_NODES = 1024
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  gbi_pkg::cfg_t cfg,
    input  logic          init_done,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    mode,
    input  logic [23:0]   pos_x,
    input  logic [23:0]   pos_z,
    input  logic [23:0]   box_min_x,
    input  logic [23:0]   box_min_z,
    input  logic [23:0]   box_max_x,
    input  logic [23:0]   box_max_z,
    input  logic [15:0]   object_id,
    input  logic [11:0]   cell_x,
    input  logic [11:0]   cell_y,
    input  logic [9:0]    node_index,
    output logic          push,
    input  logic          q_ready,
    output gbi_pkg::cmd_t cmd
);
    import gbi_pkg::*;

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_DIV   = 3'd1;
    localparam logic [2:0] F_CLAMP = 3'd2;
    localparam logic [2:0] F_MUL   = 3'd3;
    localparam logic [2:0] F_PUSH  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic        accept, div_start;
    logic [24:0] sums [4];
    logic [3:0]  div_done;
    logic [25:0] quo [4];
    logic [15:0] step;
    logic [1:0]  mode_reg;
    logic [15:0] obj_reg, node_reg;
    logic [11:0] cx_reg, cy_reg;
    logic        rej_reg;
    logic [12:0] xt1_reg, xt2_reg, yt1_reg, yt2_reg;
    logic [26:0] prod_reg;
    logic [25:0] w26, h26;
    logic        rej_c;
    logic [12:0] x1c, x2c, y1c, y2c;
    logic [13:0] row_c;
    logic [12:0] mul_a;
    logic [27:0] get_idx;

    assign in_ready  = (state_reg == F_IDLE) && init_done;
    assign accept    = in_valid && in_ready;
    assign div_start = accept && (mode == M_INSERT);
    assign step      = (cfg.cell_step == 16'd0) ? 16'd1 : cfg.cell_step;

    assign sums[0] = {pos_x[23], pos_x} + {box_min_x[23], box_min_x};
    assign sums[1] = {pos_z[23], pos_z} + {box_min_z[23], box_min_z};
    assign sums[2] = {pos_x[23], pos_x} + {box_max_x[23], box_max_x};
    assign sums[3] = {pos_z[23], pos_z} + {box_max_z[23], box_max_z};

    for (genvar i = 0; i < 4; i++)
    begin : g_div
        gbi_div u_div
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (sums[i]),
            .divisor  (step),
            .done     (div_done[i]),
            .quotient (quo[i])
        );
    end

    // Corner order: x1, y1, x2, y2.
    assign w26   = {13'd0, cfg.land_width};
    assign h26   = {13'd0, cfg.land_height};
    assign rej_c = (cfg.land_width == 13'd0) || (cfg.land_height == 13'd0)
                || ($signed(quo[0]) >= $signed(w26)) || ($signed(quo[1]) >= $signed(h26))
                || quo[2][25] || quo[3][25];
    assign x1c = quo[0][25] ? 13'd0 : quo[0][12:0];
    assign y1c = quo[1][25] ? 13'd0 : quo[1][12:0];
    assign x2c = ($signed(quo[2]) >= $signed(w26)) ? (cfg.land_width - 13'd1) : quo[2][12:0];
    assign y2c = ($signed(quo[3]) >= $signed(h26)) ? (cfg.land_height - 13'd1) : quo[3][12:0];

    assign row_c   = {1'b0, cfg.land_width >> cfg.grid_shift} + 14'd1;
    assign mul_a   = (mode_reg == M_GET) ? 13'(cy_reg >> cfg.grid_shift) : yt1_reg;
    assign get_idx = 28'(prod_reg) + 28'(cx_reg >> cfg.grid_shift);

    always_comb
    begin
        state_next = state_reg;
        push       = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (mode == M_INSERT)
                        state_next = F_DIV;
                    else if (mode == M_GET)
                        state_next = F_MUL;
                    else
                        state_next = F_PUSH;
                end
            end
            F_DIV:
            begin
                // All four dividers run in lockstep and finish together.
                if (&div_done)
                    state_next = F_CLAMP;
            end
            F_CLAMP: state_next = F_MUL;
            F_MUL:   state_next = F_PUSH;
            F_PUSH:
            begin
                push = 1'b1;
                if (q_ready)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            obj_reg  <= object_id;
            cx_reg   <= cell_x;
            cy_reg   <= cell_y;
            node_reg <= 16'(node_index);
        end
        if (state_reg == F_CLAMP)
        begin
            rej_reg <= rej_c;
            xt1_reg <= x1c >> cfg.grid_shift;
            xt2_reg <= x2c >> cfg.grid_shift;
            yt1_reg <= y1c >> cfg.grid_shift;
            yt2_reg <= y2c >> cfg.grid_shift;
        end
        if (state_reg == F_MUL)
            prod_reg <= 27'(mul_a) * 27'(row_c);
    end

    always_comb
    begin
        cmd        = '0;
        cmd.xt1    = xt1_reg;
        cmd.xt2    = xt2_reg;
        cmd.yt1    = yt1_reg;
        cmd.yt2    = yt2_reg;
        cmd.row    = row_c;
        cmd.obj    = obj_reg;
        cmd.node   = node_reg;
        cmd.status = ST_OK;
        case (mode_reg)
            M_INSERT:
            begin
                cmd.base = 28'(prod_reg);
                if (rej_reg)
                begin
                    cmd.kind   = K_FIXED;
                    cmd.status = ST_OUTSIDE;
                end
                else
                    cmd.kind = K_INSERT;
            end
            M_GET:
            begin
                cmd.base = get_idx;
                if ((13'(cx_reg) >= cfg.land_width) || (13'(cy_reg) >= cfg.land_height)
                    || (get_idx >= 28'(TILES)))
                begin
                    cmd.kind   = K_FIXED;
                    cmd.status = ST_RANGE;
                end
                else
                    cmd.kind = K_GET;
            end
            M_READ:
            begin
                if (17'(node_reg) >= 17'(POOL_NODES))
                begin
                    cmd.kind   = K_FIXED;
                    cmd.status = ST_RANGE;
                end
                else
                    cmd.kind = K_READ;
            end
            default: cmd.kind = K_CLEAR;
        endcase
    end
endmodule

FILE: sv/gbi_queue.sv
// Two-entry command queue between the front end and the back end.
// Uses gbi_pkg for the command type.
module gbi_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          push_ready,
    input  gbi_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop,
    output gbi_pkg::cmd_t pop_cmd
);
    import gbi_pkg::*;

    cmd_t       mem [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign push_ready = cnt_reg != 2'd2;
    assign pop_valid  = cnt_reg != 2'd0;
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_cmd    = mem[rp_reg];

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wp_reg] <= push_cmd;
    end
endmodule

FILE: sv/gbi_back.sv
// Back end: tile head table, visited map, node pool and the result register.
// Uses gbi_pkg; takes commands from gbi_queue.
module gbi_back
#(
    parameter int TILES      = 8192,
    parameter int POOL_NODES = 1024
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  gbi_pkg::cmd_t   q_cmd,
    output gbi_pkg::bstat_t stat,
    output logic            out_valid,
    input  logic            out_ready,
    output gbi_pkg::res_t   res
);
    import gbi_pkg::*;

    localparam int TA     = $clog2(TILES);
    localparam int NA     = $clog2(POOL_NODES);
    localparam int NODE_W = $clog2(POOL_NODES + 1);
    localparam logic [NODE_W-1:0] EMPTY = NODE_W'(POOL_NODES);

    localparam logic [2:0] B_INIT = 3'd0;
    localparam logic [2:0] B_IDLE = 3'd1;
    localparam logic [2:0] B_TILE = 3'd2;
    localparam logic [2:0] B_WR   = 3'd3;
    localparam logic [2:0] B_GET  = 3'd4;
    localparam logic [2:0] B_RD   = 3'd5;
    localparam logic [2:0] B_CLR  = 3'd6;

    logic [NODE_W-1:0] heads [TILES];
    logic              visited [TILES];
    logic [15:0]       node_obj [POOL_NODES];
    logic [NODE_W-1:0] node_link [POOL_NODES];

    logic [2:0]        state_reg, state_next;
    logic [TA-1:0]     sweep_reg, sweep_next;
    logic [NODE_W-1:0] nu_reg, nu_next;
    logic              out_valid_reg, out_valid_next;
    res_t              res_reg, res_next;
    cmd_t              cmd_reg, cmd_next;
    logic [12:0]       tx_reg, tx_next, ty_reg, ty_next;
    logic [27:0]       base_reg, base_next, idx_reg, idx_next;
    logic [13:0]       added_reg, added_next, dropped_reg, dropped_next;
    logic [27:0]       idx_c;
    logic              pop, adv;

    logic              head_we, vis_we, vis_wd, node_we;
    logic [TA-1:0]     head_wa, vis_wa, rd_idx;
    logic [NODE_W-1:0] head_wd, head_rd_reg, link_rd_reg;
    logic              vis_rd_reg;
    logic [15:0]       obj_rd_reg;

    assign idx_c  = base_reg + 28'(tx_reg);
    assign rd_idx = (state_reg == B_TILE) ? idx_c[TA-1:0] : q_cmd.base[TA-1:0];

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        nu_next        = nu_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        cmd_next       = cmd_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        base_next      = base_reg;
        idx_next       = idx_reg;
        added_next     = added_reg;
        dropped_next   = dropped_reg;
        pop            = 1'b0;
        adv            = 1'b0;
        head_we        = 1'b0;
        head_wa        = sweep_reg;
        head_wd        = EMPTY;
        vis_we         = 1'b0;
        vis_wa         = sweep_reg;
        vis_wd         = 1'b0;
        node_we        = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            B_INIT:
            begin
                head_we    = 1'b1;
                vis_we     = 1'b1;
                sweep_next = sweep_reg + TA'(1);
                if (sweep_reg == TA'(TILES - 1))
                    state_next = B_IDLE;
            end
            B_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    pop      = 1'b1;
                    cmd_next = q_cmd;
                    idx_next = q_cmd.base;
                    case (q_cmd.kind)
                        K_INSERT:
                        begin
                            tx_next      = q_cmd.xt1;
                            ty_next      = q_cmd.yt1;
                            base_next    = q_cmd.base;
                            added_next   = 14'd0;
                            dropped_next = 14'd0;
                            if ((q_cmd.xt1 > q_cmd.xt2) || (q_cmd.yt1 > q_cmd.yt2))
                            begin
                                out_valid_next = 1'b1;
                                res_next       = status_res(ST_OK);
                            end
                            else
                                state_next = B_TILE;
                        end
                        K_GET:  state_next = B_GET;
                        K_READ: state_next = B_RD;
                        K_CLEAR:
                        begin
                            sweep_next = '0;
                            state_next = B_CLR;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            res_next       = status_res(q_cmd.status);
                        end
                    endcase
                end
            end
            B_TILE:
            begin
                if (idx_c >= 28'(TILES))
                begin
                    out_valid_next = 1'b1;
                    res_next = status_res((dropped_reg != 14'd0) ? ST_EXHAUST : ST_RANGE);
                    res_next.cells_added   = added_reg;
                    res_next.cells_dropped = dropped_reg;
                    state_next = B_IDLE;
                end
                else if (nu_reg >= EMPTY)
                begin
                    dropped_next = dropped_reg + 14'd1;
                    adv          = 1'b1;
                end
                else
                begin
                    idx_next   = idx_c;
                    state_next = B_WR;
                end
            end
            B_WR:
            begin
                head_we    = 1'b1;
                head_wa    = idx_reg[TA-1:0];
                head_wd    = nu_reg;
                node_we    = 1'b1;
                nu_next    = nu_reg + NODE_W'(1);
                added_next = added_reg + 14'd1;
                adv        = 1'b1;
            end
            B_GET:
            begin
                out_valid_next = 1'b1;
                state_next     = B_IDLE;
                if (vis_rd_reg)
                    res_next = status_res(ST_VISITED);
                else
                begin
                    vis_we   = 1'b1;
                    vis_wa   = idx_reg[TA-1:0];
                    vis_wd   = 1'b1;
                    res_next = status_res(ST_OK);
                    if (head_rd_reg != EMPTY)
                    begin
                        res_next.head_valid = 1'b1;
                        res_next.head_node  = 10'(head_rd_reg);
                    end
                end
            end
            B_RD:
            begin
                out_valid_next       = 1'b1;
                state_next           = B_IDLE;
                res_next             = status_res(ST_OK);
                res_next.node_object = obj_rd_reg;
                if (link_rd_reg != EMPTY)
                begin
                    res_next.next_valid = 1'b1;
                    res_next.next_node  = 10'(link_rd_reg);
                end
            end
            B_CLR:
            begin
                vis_we     = 1'b1;
                sweep_next = sweep_reg + TA'(1);
                if (sweep_reg == TA'(TILES - 1))
                begin
                    out_valid_next = 1'b1;
                    res_next       = status_res(ST_OK);
                    state_next     = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase

        // Step to the next tile in row-major order, or finish the insert.
        if (adv)
        begin
            if (tx_reg == cmd_reg.xt2)
            begin
                if (ty_reg == cmd_reg.yt2)
                begin
                    out_valid_next = 1'b1;
                    res_next = status_res((dropped_next != 14'd0) ? ST_EXHAUST : ST_OK);
                    res_next.cells_added   = added_next;
                    res_next.cells_dropped = dropped_next;
                    state_next = B_IDLE;
                end
                else
                begin
                    tx_next    = cmd_reg.xt1;
                    ty_next    = ty_reg + 13'd1;
                    base_next  = base_reg + 28'(cmd_reg.row);
                    state_next = B_TILE;
                end
            end
            else
            begin
                tx_next    = tx_reg + 13'd1;
                state_next = B_TILE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            sweep_reg     <= '0;
            nu_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            nu_reg        <= nu_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        cmd_reg     <= cmd_next;
        tx_reg      <= tx_next;
        ty_reg      <= ty_next;
        base_reg    <= base_next;
        idx_reg     <= idx_next;
        added_reg   <= added_next;
        dropped_reg <= dropped_next;
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            heads[head_wa] <= head_wd;
        head_rd_reg <= heads[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
            visited[vis_wa] <= vis_wd;
        vis_rd_reg <= visited[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_obj[nu_reg[NA-1:0]]  <= cmd_reg.obj;
            node_link[nu_reg[NA-1:0]] <= head_rd_reg;
        end
        obj_rd_reg  <= node_obj[q_cmd.node[NA-1:0]];
        link_rd_reg <= node_link[q_cmd.node[NA-1:0]];
    end

    assign stat.init_done = state_reg != B_INIT;
    assign stat.pop       = pop;
    assign out_valid      = out_valid_reg;
    assign res            = res_reg;
endmodule

FILE: sv/grid_bucket_insert_and_visit.sv
// Top level of the grid bucket insert and visit block: configuration registers,
// front end, command queue and back end. Uses gbi_pkg and all gbi_* modules.
//
// Usage. Items arrive on the s_axis channel; s_axis_tuser carries the mode
// (insert, get tile, read node, clear visited flags) and s_axis_tdata the
// operands. Each item yields exactly one result item on m_axis, in order.
// Registers land_width, land_height, cell_step and grid_shift are written on
// the cfg port (cfg_we, cfg_index, cfg_data) while the block is idle.
// An insert passes the corner dividers, then clamping and the multiply, then
// the back end states B_TILE and B_WR for each covered tile (B_TILE alone for
// a tile dropped because the pool is exhausted). A get or read passes the back
// end state B_GET or B_RD; a get or read whose check fails is answered directly.
// Clear walks the visited map, one tile per cycle. The read-modify-write of the
// tile head table and of the visited map sets the pace.
// After reset the back end sweeps the head table and the visited map;
// s_axis_tready stays low until it is done. The front end keeps
// accepting and preparing items while the back end is busy, through a
// two-entry queue. A finished result waits in the output register for as
// long as m_axis_tready is low; the back end then holds, and the front end
// stalls once the queue is full.
module grid_bucket_insert_and_visit
#(
    parameter int TILES      = 8192,
    parameter int POOL_NODES = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x[23:0], pos_z[47:24], box_min_x[71:48], box_min_z[95:72],
    // box_max_x[119:96], box_max_z[143:120], object_id[159:144],
    // cell_x[171:160], cell_y[183:172], node_index[193:184], zero fill
    input  logic [199:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], head_valid[3], head_node[13:4], node_object[29:14],
    // next_valid[30], next_node[40:31], cells_added[54:41],
    // cells_dropped[68:55], zero fill
    output logic [71:0]  m_axis_tdata
);
    import gbi_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    cmd_t   f_cmd, q_cmd;
    logic   f_push, q_ready, q_valid;
    bstat_t bstat;
    res_t   res;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                R_LAND_WIDTH:  cfg_next.land_width  = cfg_data[12:0];
                R_LAND_HEIGHT: cfg_next.land_height = cfg_data[12:0];
                R_CELL_STEP:   cfg_next.cell_step   = cfg_data;
                R_GRID_SHIFT:  cfg_next.grid_shift  = cfg_data[2:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.land_width  <= 13'd1024;
            cfg_reg.land_height <= 13'd1024;
            cfg_reg.cell_step   <= 16'd256;
            cfg_reg.grid_shift  <= 3'd4;
        end
        else
            cfg_reg <= cfg_next;
    end

    gbi_front #(.TILES(TILES), .POOL_NODES(POOL_NODES)) u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .init_done  (bstat.init_done),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .mode       (s_axis_tuser),
        .pos_x      (s_axis_tdata[23:0]),
        .pos_z      (s_axis_tdata[47:24]),
        .box_min_x  (s_axis_tdata[71:48]),
        .box_min_z  (s_axis_tdata[95:72]),
        .box_max_x  (s_axis_tdata[119:96]),
        .box_max_z  (s_axis_tdata[143:120]),
        .object_id  (s_axis_tdata[159:144]),
        .cell_x     (s_axis_tdata[171:160]),
        .cell_y     (s_axis_tdata[183:172]),
        .node_index (s_axis_tdata[193:184]),
        .push       (f_push),
        .q_ready    (q_ready),
        .cmd        (f_cmd)
    );

    gbi_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_push),
        .push_ready (q_ready),
        .push_cmd   (f_cmd),
        .pop_valid  (q_valid),
        .pop        (bstat.pop),
        .pop_cmd    (q_cmd)
    );

    gbi_back #(.TILES(TILES), .POOL_NODES(POOL_NODES)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .stat      (bstat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {3'd0, res.cells_dropped, res.cells_added, res.next_node,
                           res.next_valid, res.node_object, res.head_node,
                           res.head_valid, res.status};

`ifndef NO_ASSERTIONS
    // No item is taken while the tables are still being swept after reset.
    a_ready_after_init: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> bstat.init_done)
        else $error("item accepted before the reset sweep finished");

    // The front end never pushes into a full queue without waiting.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (f_push && !q_ready) |=> f_push)
        else $error("command dropped at the queue");

    // The back end only starts a command when the result register is free.
    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.pop |-> (q_valid && !m_axis_tvalid))
        else $error("command started while a result is pending");
`endif
endmodule

FILE: tb/grid_bucket_insert_and_visit_tb.sv
// Self-checking testbench for grid_bucket_insert_and_visit: binning inserts, tile gets,
// node reads and visited-map clears, checked against a predictor kept inside the bench.
// Depends on gbi_pkg and the RTL of the block only.
module grid_bucket_insert_and_visit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gbi_pkg::*;

    localparam int TILES      = 8192;
    localparam int POOL_NODES = 1024;
    localparam int EMPTY_HEAD = POOL_NODES;
    localparam longint CYCLE_LIMIT = 6000000;

    // One request item as the sender sees it.
    typedef struct {
        logic [1:0]         mode;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_z;
        logic signed [23:0] min_x;
        logic signed [23:0] min_z;
        logic signed [23:0] max_x;
        logic signed [23:0] max_z;
        logic [15:0]        object_id;
        logic [11:0]        cell_x;
        logic [11:0]        cell_y;
        logic [9:0]         node_index;
    } request_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;

    grid_bucket_insert_and_visit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Mirror of the block's registers and storage, kept by the predictor.
    cfg_t        grid_cfg;
    logic [10:0] tile_head [TILES];
    logic [15:0] node_obj [POOL_NODES];
    logic [10:0] node_next [POOL_NODES];
    logic        node_has_next [POOL_NODES];
    logic        tile_seen [TILES];
    int          nodes_used;

    request_t    request_queue[$];
    res_t        result_queue[$];
    request_t    cur_req;
    logic        req_taken;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          mismatches;
    longint      cycle_count;
    int          n_inserts, n_gets, n_reads, n_clears, n_results, n_drop_results;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Work out the result of one accepted item and update the mirrored state, the way
    // the block does: inserts prepend nodes in row-major tile order, gets mark tiles.
    function automatic res_t bin_request(input request_t rq);
        res_t r;
        int   step, w, h, x1, y1, x2, y2, row, idx;
        int   xt1, xt2, yt1, yt2, added, dropped;
        bit   beyond, stop;
        r = '0;
        row = (int'(grid_cfg.land_width) >> grid_cfg.grid_shift) + 1;
        case (rq.mode)
            M_INSERT:
            begin
                step = (grid_cfg.cell_step == 0) ? 1 : int'(grid_cfg.cell_step);
                w = grid_cfg.land_width;
                h = grid_cfg.land_height;
                // Division of int truncates toward zero, which is what the block does.
                x1 = (int'(rq.pos_x) + int'(rq.min_x)) / step;
                y1 = (int'(rq.pos_z) + int'(rq.min_z)) / step;
                x2 = (int'(rq.pos_x) + int'(rq.max_x)) / step;
                y2 = (int'(rq.pos_z) + int'(rq.max_z)) / step;
                if (w == 0 || h == 0 || x1 >= w || y1 >= h || x2 < 0 || y2 < 0)
                begin
                    r.status = ST_OUTSIDE;
                    return r;
                end
                if (x1 < 0) x1 = 0;
                if (y1 < 0) y1 = 0;
                if (x2 >= w) x2 = w - 1;
                if (y2 >= h) y2 = h - 1;
                xt1 = x1 >> grid_cfg.grid_shift;
                xt2 = x2 >> grid_cfg.grid_shift;
                yt1 = y1 >> grid_cfg.grid_shift;
                yt2 = y2 >> grid_cfg.grid_shift;
                added = 0;
                dropped = 0;
                beyond = 0;
                stop = 0;
                for (int ty = yt1; ty <= yt2 && !stop; ty++)
                begin
                    for (int tx = xt1; tx <= xt2; tx++)
                    begin
                        idx = ty * row + tx;
                        if (idx >= TILES)
                        begin
                            beyond = 1;
                            stop = 1;
                            break;
                        end
                        if (nodes_used >= POOL_NODES)
                        begin
                            dropped++;
                            continue;
                        end
                        node_obj[nodes_used] = rq.object_id;
                        node_has_next[nodes_used] = (tile_head[idx] != EMPTY_HEAD);
                        node_next[nodes_used] = tile_head[idx];
                        tile_head[idx] = 11'(nodes_used);
                        nodes_used++;
                        added++;
                    end
                end
                r.status = dropped != 0 ? ST_EXHAUST : (beyond ? ST_RANGE : ST_OK);
                r.cells_added = 14'(added);
                r.cells_dropped = 14'(dropped);
            end
            M_GET:
            begin
                idx = (int'(rq.cell_y) >> grid_cfg.grid_shift) * row
                      + (int'(rq.cell_x) >> grid_cfg.grid_shift);
                if (rq.cell_x >= grid_cfg.land_width || rq.cell_y >= grid_cfg.land_height
                    || idx >= TILES)
                    r.status = ST_RANGE;
                else if (tile_seen[idx])
                    r.status = ST_VISITED;
                else
                begin
                    tile_seen[idx] = 1'b1;
                    if (tile_head[idx] != EMPTY_HEAD)
                    begin
                        r.head_valid = 1'b1;
                        r.head_node = tile_head[idx][9:0];
                    end
                end
            end
            M_READ:
            begin
                r.node_object = node_obj[rq.node_index];
                if (node_has_next[rq.node_index])
                begin
                    r.next_valid = 1'b1;
                    r.next_node = node_next[rq.node_index][9:0];
                end
            end
            default:
            begin
                foreach (tile_seen[i]) tile_seen[i] = 1'b0;
            end
        endcase
        return r;
    endfunction

    // Sender: a new item is presented at the falling edge once the previous one is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || req_taken))
        begin
            if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cur_req = request_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= cur_req.mode;
                s_axis_tdata  <= {6'b0, cur_req.node_index, cur_req.cell_y, cur_req.cell_x,
                                  cur_req.object_id, cur_req.max_z, cur_req.max_x,
                                  cur_req.min_z, cur_req.min_x, cur_req.pos_z, cur_req.pos_x};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Accept side and result checker, both sampled at the rising edge.
    always @(posedge clk)
    begin
        res_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
        req_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            result_queue.push_back(bin_request(cur_req));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (result_queue.size() == 0)
            begin
                $error("result item arrived with no result expected");
                mismatches++;
            end
            else
            begin
                want = result_queue.pop_front();
                if (want.cells_dropped != 0) n_drop_results++;
                check_field("status", want.status, m_axis_tdata[2:0]);
                check_field("head_valid", want.head_valid, m_axis_tdata[3]);
                check_field("head_node", want.head_node, m_axis_tdata[13:4]);
                check_field("node_object", want.node_object, m_axis_tdata[29:14]);
                check_field("next_valid", want.next_valid, m_axis_tdata[30]);
                check_field("next_node", want.next_node, m_axis_tdata[40:31]);
                check_field("cells_added", want.cells_added, m_axis_tdata[54:41]);
                check_field("cells_dropped", want.cells_dropped, m_axis_tdata[68:55]);
            end
        end
    end

    task automatic write_reg(input logic [1:0] index, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value[15:0];
        case (index)
            R_LAND_WIDTH:  grid_cfg.land_width  = value[12:0];
            R_LAND_HEIGHT: grid_cfg.land_height = value[12:0];
            R_CELL_STEP:   grid_cfg.cell_step   = value[15:0];
            default:       grid_cfg.grid_shift  = value[2:0];
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Let everything drain; every item yields a result, the extra cycles are margin.
    task automatic wait_drained();
        while (request_queue.size() > 0 || s_axis_tvalid || result_queue.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_grid(input int w, input int h, input int step, input int shift);
        wait_drained();
        write_reg(R_LAND_WIDTH, w);
        write_reg(R_LAND_HEIGHT, h);
        write_reg(R_CELL_STEP, step);
        write_reg(R_GRID_SHIFT, shift);
    endtask

    task automatic send(input request_t rq);
        // Keep the predictor close behind so node reads only touch written nodes.
        while (request_queue.size() > 3) @(posedge clk);
        case (rq.mode)
            M_INSERT: n_inserts++;
            M_GET:    n_gets++;
            M_READ:   n_reads++;
            default:  n_clears++;
        endcase
        request_queue.push_back(rq);
    endtask

    function automatic request_t make_insert(input int px, input int pz, input int mnx,
                                             input int mnz, input int mxx, input int mxz);
        request_t rq;
        rq = '{default: '0};
        rq.mode = M_INSERT;
        rq.pos_x = 24'(px);
        rq.pos_z = 24'(pz);
        rq.min_x = 24'(mnx);
        rq.min_z = 24'(mnz);
        rq.max_x = 24'(mxx);
        rq.max_z = 24'(mxz);
        rq.object_id = 16'($urandom_range(65535));
        return rq;
    endfunction

    function automatic request_t make_get(input int cx, input int cy);
        request_t rq;
        rq = '{default: '0};
        rq.mode = M_GET;
        rq.cell_x = 12'(cx);
        rq.cell_y = 12'(cy);
        return rq;
    endfunction

    function automatic request_t make_other(input logic [1:0] mode, input int node);
        request_t rq;
        rq = '{default: '0};
        rq.mode = mode;
        rq.node_index = 10'(node);
        return rq;
    endfunction

    // Random item: mostly boxes of a few cells around the map, a tenth inverted and
    // a tenth pure noise; gets mostly aimed into the map; reads only of written nodes.
    function automatic request_t random_request();
        request_t rq;
        int  pick, st, w, h, px, pz, a, b;
        pick = $urandom_range(99);
        st = (grid_cfg.cell_step == 0) ? 1 : int'(grid_cfg.cell_step);
        w = grid_cfg.land_width;
        h = grid_cfg.land_height;
        if (pick < 42)
        begin
            px = ($urandom_range(w + 6) - 3) * st + $urandom_range(st - 1);
            pz = ($urandom_range(h + 6) - 3) * st + $urandom_range(st - 1);
            rq = make_insert(px, pz, -int'($urandom_range(st * 3)), -int'($urandom_range(st * 3)),
                             $urandom_range(st * 3), $urandom_range(st * 3));
            a = $urandom_range(9);
            if (a == 0)
            begin
                b = rq.min_x; rq.min_x = rq.max_x + 24'sd1; rq.max_x = 24'(b);
            end
            else if (a == 1)
            begin
                rq.pos_x = 24'($urandom); rq.pos_z = 24'($urandom);
                rq.min_x = 24'($urandom); rq.min_z = 24'($urandom);
                rq.max_x = 24'($urandom); rq.max_z = 24'($urandom);
            end
        end
        else if (pick < 72 || nodes_used == 0)
        begin
            if ($urandom_range(4) == 0 || w == 0 || h == 0)
                rq = make_get($urandom_range(4095), $urandom_range(4095));
            else
                rq = make_get($urandom_range(w - 1), $urandom_range(h - 1));
        end
        else if (pick < 99)
            rq = make_other(M_READ, $urandom_range(nodes_used - 1));
        else
            rq = make_other(M_CLEAR, 0);
        return rq;
    endfunction

    task automatic random_run(input int count);
        for (int i = 0; i < count; i++)
            send(random_request());
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = R_LAND_WIDTH;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = M_INSERT;
        m_axis_tready = 1'b0;
        req_taken = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        n_inserts = 0; n_gets = 0; n_reads = 0; n_clears = 0;
        n_results = 0; n_drop_results = 0;
        send_idle_pct = 25;
        recv_idle_pct = 54;
        grid_cfg.land_width = 1024;
        grid_cfg.land_height = 1024;
        grid_cfg.cell_step = 256;
        grid_cfg.grid_shift = 4;
        foreach (tile_head[i]) tile_head[i] = EMPTY_HEAD;
        foreach (tile_seen[i]) tile_seen[i] = 1'b0;
        foreach (node_obj[i])
        begin
            node_obj[i] = '0;
            node_next[i] = '0;
            node_has_next[i] = 1'b0;
        end
        nodes_used = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part on the reset-value grid (16 fine cells per tile, 256 per cell).
        set_grid(1024, 1024, 256, 4);
        send(make_insert(0, 0, 0, 0, 255, 255));                       // corner tile
        send(make_insert(-8388608, -8388608, -8388608, -8388608,
                         -8388608, -8388608));                         // fully outside
        send(make_insert(8388607, 8388607, 8388607, 8388607,
                         8388607, 8388607));                           // outside, far side
        send(make_insert(100 * 256, 40 * 256, 1000, 1000, 0, 0));      // inverted, one tile
        send(make_insert(100 * 256, 40 * 256, 4000, 0, -4000, 0));     // inverted, spans tiles
        send(make_insert(-600, -600, 0, 0, 40 * 256, 20 * 256));       // clamped at low edge
        send(make_insert(1000 * 256, 1000 * 256, 0, 0, 9000, 9000));   // clamped at high edge
        send(make_get(0, 0));
        send(make_get(5, 5));                                          // already visited
        send(make_get(600, 600));                                      // empty tile
        send(make_get(4095, 0));                                       // out of range
        send(make_get(0, 4095));
        send(make_get(100, 40));
        send(make_get(1023, 1023));
        send(make_other(M_READ, 0));
        send(make_other(M_READ, 1));
        send(make_other(M_CLEAR, 0));
        send(make_get(0, 0));
        send(random_request());
        random_run(560);

        // Small map: fills the pool quickly, so drops and deep reads follow.
        send_idle_pct = 54;
        recv_idle_pct = 25;
        set_grid(64, 48, 100, 2);
        random_run(600);
        send(make_insert(0, 0, 0, 0, 6400, 4800));                     // whole map, drops

        // A 4096 by 4096 grid, largest step, one cell per tile: rows run past the table.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_grid(4096, 4096, 65535, 0);
        send(make_insert(0, 0, 0, 0, 8388607, 8388607));
        send(make_get(4095, 4095));
        send(make_get(0, 1));
        random_run(150);

        // Empty map with a zero cell step and a grid shift of 6.
        set_grid(0, 0, 0, 6);
        send(make_insert(0, 0, 0, 0, 100, 100));
        random_run(60);

        // One-cell map with the finest step.
        set_grid(1, 1, 1, 6);
        send(make_insert(0, 0, -5, -5, 5, 5));
        send(make_get(0, 0));
        random_run(60);

        set_grid(200, 300, 256, 3);
        random_run(380);

        wait_drained();
        $display("Covered %0d inserts, %0d gets, %0d reads, %0d clears over six grid settings.",
                 n_inserts, n_gets, n_reads, n_clears);
        $display("Checked %0d result items, %0d of them with pool drops; nodes used %0d.",
                 n_results, n_drop_results, nodes_used);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
sv/gbi_pkg.sv
sv/gbi_div.sv
sv/gbi_front.sv
sv/gbi_queue.sv
sv/gbi_back.sv
sv/grid_bucket_insert_and_visit.sv
tb/grid_bucket_insert_and_visit_tb.sv
